// ===== rtl/m4vt_pkg.sv =====
// Shared types and constants for the 4x4 matrix-vector transform.
`timescale 1ns / 1ps
`default_nettype none
package m4vt_pkg;

	localparam int ELEM_W = 32;
	localparam int DIM = 4;
	localparam int ROW_W = 2;
	localparam int FRAC_BITS_DEF = 16;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef elem_t [DIM-1:0] vec_t;

	// request kind
	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_XFORM = 1'b1
	} kind_t;

endpackage
`default_nettype wire

// ===== rtl/m4vt_cmd_if.sv =====
// Request channel: load a matrix row or transform a vector.
`timescale 1ns / 1ps
`default_nettype none
interface m4vt_cmd_if;
	import m4vt_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	logic  [ROW_W-1:0] row_index;
	elem_t elem0;
	elem_t elem1;
	elem_t elem2;
	elem_t elem3;

	modport source(output valid, kind, row_index, elem0, elem1, elem2, elem3, input ready);
	modport sink(input valid, kind, row_index, elem0, elem1, elem2, elem3, output ready);
endinterface
`default_nettype wire

// ===== rtl/m4vt_res_if.sv =====
// Result channel: transformed vector and saturation flag.
`timescale 1ns / 1ps
`default_nettype none
interface m4vt_res_if;
	import m4vt_pkg::*;

	logic  valid;
	logic  ready;
	elem_t out0;
	elem_t out1;
	elem_t out2;
	elem_t out3;
	logic  saturated;

	modport source(output valid, out0, out1, out2, out3, saturated, input ready);
	modport sink(input valid, out0, out1, out2, out3, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/m4vt_row_dot.sv =====
// Pipelined dot product of one matrix row with a vector, shifted and saturated.
`timescale 1ns / 1ps
`default_nettype none
module m4vt_row_dot #(
	parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire m4vt_pkg::vec_t row,
	input  wire m4vt_pkg::vec_t vec,
	output m4vt_pkg::elem_t     result_q,
	output logic                sat_q
);
	import m4vt_pkg::*;

	localparam int PROD_W = 2 * ELEM_W;
	localparam int PAIR_W = PROD_W + 1;
	localparam int SUM_W  = PROD_W + 2;

	logic signed [PROD_W-1:0] prod_s2 [DIM];
	logic signed [PAIR_W-1:0] pair_s3 [DIM/2];
	logic signed [SUM_W-1:0]  sum_s4;
	logic signed [SUM_W-1:0]  shifted;
	logic                     fits;

	// stage 2: four full products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DIM; j++) begin
				prod_s2[j] <= PROD_W'(row[j]) * PROD_W'(vec[j]);
			end
		end
	end

	// stage 3: pairwise sums
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIM/2; k++) begin
				pair_s3[k] <= PAIR_W'(prod_s2[2*k]) + PAIR_W'(prod_s2[2*k+1]);
			end
		end
	end

	// stage 4: exact row sum
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= SUM_W'(pair_s3[0]) + SUM_W'(pair_s3[1]);
		end
	end

	// scale down, then clip if the upper bits are not all sign copies
	always_comb begin
		shifted = sum_s4 >>> FRAC_BITS;
		fits    = (&shifted[SUM_W-1:ELEM_W-1]) | ~(|shifted[SUM_W-1:ELEM_W-1]);
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (fits) begin
				result_q <= shifted[ELEM_W-1:0];
				sat_q    <= 1'b0;
			end else if (shifted[SUM_W-1]) begin
				result_q <= {1'b1, {(ELEM_W-1){1'b0}}};
				sat_q    <= 1'b1;
			end else begin
				result_q <= {1'b0, {(ELEM_W-1){1'b1}}};
				sat_q    <= 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/matrix4x4_vector_transform_core.sv =====
// Top level of the 4x4 matrix-vector transform core.
// Holds a 4x4 signed fixed-point matrix (Q16.16 by default, FRAC_BITS fraction
// bits), zero after reset. A load request (kind = load) overwrites matrix row
// row_index with elem0..3 and returns nothing; a transform request multiplies
// the matrix by the vector elem0..3 and returns out0..3, each the exact sum of
// four 64-bit products shifted right arithmetically by FRAC_BITS and clipped to
// 32 bits, with saturated set if any element was clipped. One request is
// accepted per cycle unless the pipeline is held; a transform result passes
// through five register stages (input register, sixteen parallel 32x32
// multipliers, two adder levels, saturation into the output register). A load
// takes effect for every transform accepted after it. The whole pipeline holds
// while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none
module matrix4x4_vector_transform_core #(
	parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	m4vt_cmd_if.sink  cmd,
	m4vt_res_if.source res
);
	import m4vt_pkg::*;

	logic en;
	vec_t matrix_q [DIM];
	vec_t vec_s1;
	logic valid_s1, valid_s2, valid_s3, valid_s4, res_valid_q;
	elem_t result [DIM];
	logic  [DIM-1:0] sat;

	// pipeline advances unless a finished result is held
	assign en = !res_valid_q || res.ready;
	assign cmd.ready = en;

	// matrix store, row written by a load request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIM; i++) begin
				matrix_q[i] <= '0;
			end
		end else if (cmd.valid && en && cmd.kind == KIND_LOAD) begin
			matrix_q[cmd.row_index] <= {cmd.elem3, cmd.elem2, cmd.elem1, cmd.elem0};
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= cmd.valid && cmd.kind == KIND_XFORM;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			res_valid_q <= valid_s4;
		end
	end

	// stage 1: vector register
	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= {cmd.elem3, cmd.elem2, cmd.elem1, cmd.elem0};
		end
	end

	// one dot-product pipeline per matrix row
	for (genvar r = 0; r < DIM; r++) begin : g_row
		m4vt_row_dot #(
			.FRAC_BITS(FRAC_BITS)
		) u_row_dot (
			.clk     (clk),
			.en      (en),
			.row     (matrix_q[r]),
			.vec     (vec_s1),
			.result_q(result[r]),
			.sat_q   (sat[r])
		);
	end

	assign res.valid     = res_valid_q;
	assign res.out0      = result[0];
	assign res.out1      = result[1];
	assign res.out2      = result[2];
	assign res.out3      = result[3];
	assign res.saturated = |sat;
endmodule
`default_nettype wire

// ===== tb/matrix4x4_vector_transform_core_tb.sv =====
// Self-checking testbench for the 4x4 matrix-vector transform core.
`timescale 1ns / 1ps
module matrix4x4_vector_transform_core_tb;
	import m4vt_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam int RAND_ITEMS = 1050;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;

	localparam elem_t Q_ONE = 32'sh0001_0000;
	localparam elem_t Q_MAX = 32'sh7FFF_FFFF;
	localparam elem_t Q_MIN = 32'sh8000_0000;
	localparam logic signed [69:0] SUM_MAX = 70'sh7FFF_FFFF;
	localparam logic signed [69:0] SUM_MIN = -70'sh8000_0000;

	typedef struct packed {
		kind_t            kind;
		logic [ROW_W-1:0] row_index;
		vec_t             v;
	} mat_req_t;

	typedef struct packed {
		vec_t outv;
		logic sat;
	} xform_res_t;

	typedef struct packed {
		mat_req_t   rq;
		logic       lit;
		xform_res_t lit_res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic no_idle;
	int   fail_count = 0;
	int   quiet_cycles = 0;

	vec_t       matrix_rows [DIM];
	xform_res_t product_q [$];
	stim_row_t  stim_tab [$];

	m4vt_cmd_if cmd_ch();
	m4vt_res_if res_ch();

	matrix4x4_vector_transform_core #(
		.FRAC_BITS(FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch.sink),
		.res(res_ch.source)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic vec_t vec4(elem_t e0, elem_t e1, elem_t e2, elem_t e3);
		vec_t v;
		v[0] = e0;
		v[1] = e1;
		v[2] = e2;
		v[3] = e3;
		return v;
	endfunction

	// matrix times vector: exact sum, floor shift, clip to 32 bits
	function automatic xform_res_t transform_vec(vec_t v);
		xform_res_t r;
		logic signed [69:0] acc;
		logic signed [69:0] shifted;
		r.sat = 1'b0;
		for (int i = 0; i < DIM; i++) begin
			acc = '0;
			for (int j = 0; j < DIM; j++)
				acc = acc + $signed(matrix_rows[i][j]) * $signed(v[j]);
			shifted = acc >>> FRAC;
			if (shifted > SUM_MAX) begin
				r.outv[i] = Q_MAX;
				r.sat = 1'b1;
			end else if (shifted < SUM_MIN) begin
				r.outv[i] = Q_MIN;
				r.sat = 1'b1;
			end else begin
				r.outv[i] = shifted[31:0];
			end
		end
		return r;
	endfunction

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic elem_t rand_elem(bit narrow);
		if (narrow) begin
			case ($urandom_range(3))
				0, 1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
				2: return ($urandom_range(0, 16) - 8) * Q_ONE;
				default: return $urandom_range(0, 3) - 1;
			endcase
		end
		case ($urandom_range(7))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return '1;
			4: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic vec_t rand_vec(bit narrow);
		return vec4(rand_elem(narrow), rand_elem(narrow), rand_elem(narrow), rand_elem(narrow));
	endfunction

	task automatic add_row(kind_t k, int row, vec_t v, logic lit, vec_t o, logic s);
		stim_row_t t;
		t.rq.kind = k;
		t.rq.row_index = ROW_W'(row);
		t.rq.v = v;
		t.lit = lit;
		t.lit_res.outv = o;
		t.lit_res.sat = s;
		stim_tab.push_back(t);
	endtask

	// drive one request, hold until taken, then update the matrix or queue the product
	task automatic issue_request(mat_req_t rq, logic lit, xform_res_t lit_res);
		int gap;
		cmd_ch.valid <= 1'b1;
		cmd_ch.kind <= rq.kind;
		cmd_ch.row_index <= rq.row_index;
		cmd_ch.elem0 <= rq.v[0];
		cmd_ch.elem1 <= rq.v[1];
		cmd_ch.elem2 <= rq.v[2];
		cmd_ch.elem3 <= rq.v[3];
		@(posedge clk);
		while (cmd_ch.ready !== 1'b1)
			@(posedge clk);
		if (rq.kind == KIND_LOAD)
			matrix_rows[rq.row_index] = rq.v;
		else
			product_q.push_back(lit ? lit_res : transform_vec(rq.v));
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and wait for every queued product
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (product_q.size() != 0);
	endtask

	// stimulus
	initial begin
		mat_req_t rq;
		int n_sent;
		int n_xf;
		int off;
		bit paused;
		bit narrow_m;
		bit narrow_v;

		arst_n <= 1'b0;
		no_idle = 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.kind <= KIND_LOAD;
		cmd_ch.row_index <= '0;
		cmd_ch.elem0 <= '0;
		cmd_ch.elem1 <= '0;
		cmd_ch.elem2 <= '0;
		cmd_ch.elem3 <= '0;
		for (int r = 0; r < DIM; r++)
			matrix_rows[r] = '0;

		// directed table; literal expectations only where obvious
		add_row(KIND_XFORM, 3, vec4(Q_MAX, Q_MIN, -1, Q_ONE), 1'b1, '0, 1'b0);
		add_row(KIND_LOAD, 0, vec4(Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b0, '0, 1'b0);
		add_row(KIND_LOAD, 1, vec4(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b0, '0, 1'b0);
		add_row(KIND_LOAD, 2, vec4(Q_ONE, 0, 0, 0), 1'b0, '0, 1'b0);
		add_row(KIND_LOAD, 3, vec4(0, 0, 0, Q_ONE), 1'b0, '0, 1'b0);
		add_row(KIND_XFORM, 0, vec4(Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1,
			vec4(Q_MAX, Q_MIN, Q_MAX, Q_MAX), 1'b1);
		add_row(KIND_XFORM, 0, vec4(Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b1,
			vec4(Q_MIN, Q_MAX, Q_MIN, Q_MIN), 1'b1);
		add_row(KIND_XFORM, 1, vec4(Q_ONE, Q_ONE, Q_ONE, Q_ONE), 1'b0, '0, 1'b0);
		add_row(KIND_XFORM, 2, vec4(1, 0, 0, -1), 1'b0, '0, 1'b0);
		add_row(KIND_LOAD, 2, vec4(1, 0, 0, 0), 1'b0, '0, 1'b0);
		// floor rounding of small negative and positive sums
		add_row(KIND_XFORM, 3, vec4(-1, 0, 0, 0), 1'b0, '0, 1'b0);
		add_row(KIND_XFORM, 0, vec4(1, 0, 0, 0), 1'b0, '0, 1'b0);
		// one step past the positive limit, exactly at the negative limit
		add_row(KIND_LOAD, 0, vec4(32'sh4000_0000, 32'sh4000_0000, 0, 0), 1'b0, '0, 1'b0);
		add_row(KIND_LOAD, 1, vec4(Q_MIN, 0, 0, 0), 1'b0, '0, 1'b0);
		add_row(KIND_LOAD, 3, vec4(-1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0001_8000),
			1'b0, '0, 1'b0);
		add_row(KIND_XFORM, 1, vec4(Q_ONE, Q_ONE, 0, 0), 1'b0, '0, 1'b0);
		add_row(KIND_XFORM, 2, vec4(Q_ONE, -Q_ONE, Q_ONE, -Q_ONE), 1'b0, '0, 1'b0);
		add_row(KIND_XFORM, 3, vec4(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh1234_5678,
			32'shFEDC_BA98), 1'b0, '0, 1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_tab[i])
			issue_request(stim_tab[i].rq, stim_tab[i].lit, stim_tab[i].lit_res);
		drain_results();

		// random part: mostly full matrix loads followed by column streams
		n_sent = 0;
		paused = 1'b0;
		while (n_sent < RAND_ITEMS) begin
			no_idle = ((n_sent / 128) % 4 == 2);
			if (!paused && n_sent >= RAND_ITEMS / 2) begin
				paused = 1'b1;
				drain_results();
			end
			if ($urandom_range(9) < 7) begin
				if ($urandom_range(2) != 0) begin
					narrow_m = 1'($urandom_range(1));
					off = $urandom_range(DIM - 1);
					for (int r = 0; r < DIM; r++) begin
						rq.kind = KIND_LOAD;
						rq.row_index = ROW_W'((r + off) % DIM);
						rq.v = rand_vec(narrow_m);
						issue_request(rq, 1'b0, '0);
						n_sent++;
					end
				end
				n_xf = $urandom_range(1, 8);
				narrow_v = 1'($urandom_range(1));
				for (int k = 0; k < n_xf; k++) begin
					rq.kind = KIND_XFORM;
					rq.row_index = ROW_W'($urandom);
					rq.v = rand_vec(narrow_v);
					issue_request(rq, 1'b0, '0);
					n_sent++;
				end
			end else begin
				rq.kind = kind_t'($urandom_range(1));
				rq.row_index = ROW_W'($urandom);
				rq.v = rand_vec(1'($urandom_range(1)));
				issue_request(rq, 1'b0, '0);
				n_sent++;
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("matrix4x4_vector_transform_core_tb passed");
		else
			$display("matrix4x4_vector_transform_core_tb failed");
		$finish;
	end

	// result-side backpressure
	initial begin
		int hold;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			hold = no_idle ? 0 : pick_gap();
			if (hold > 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// compare each accepted result with the oldest queued product
	always @(posedge clk) begin : res_check
		xform_res_t want;
		vec_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (product_q.size() == 0) begin
				$error("result with no request pending");
				fail_count++;
			end else begin
				want = product_q.pop_front();
				got = vec4(res_ch.out0, res_ch.out1, res_ch.out2, res_ch.out3);
				for (int i = 0; i < DIM; i++) begin
					if (got[i] !== want.outv[i]) begin
						$error("out%0d: expected %h, actual %h", i, want.outv[i], got[i]);
						fail_count++;
					end
				end
				if (res_ch.saturated !== want.sat) begin
					$error("saturated: expected %b, actual %b", want.sat, res_ch.saturated);
					fail_count++;
				end
			end
		end
	end

	// watchdog: cycles with no request or result taken
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("matrix4x4_vector_transform_core_tb failed");
		$finish;
	end

endmodule
